// ===== hdl/ssisd_pkg.sv =====
// ----------------------------------------------------------------------------
// ssisd_pkg: shared types and constants of the sorted set unit
// Command and status codes, the control bundle that drives the cell row and a
// one-hot to index encoder.
// ----------------------------------------------------------------------------
package ssisd_pkg;

	localparam int CAPACITY = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;
	localparam int POS_W    = 6;
	localparam int KIND_W   = 3;
	localparam int STAT_W   = 3;

	// request kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 3'd0,
		KIND_SEARCH = 3'd1,
		KIND_DELETE = 3'd2,
		KIND_DUMP   = 3'd3,
		KIND_CLEAR  = 3'd4
	} kind_t;

	// result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FOUND     = 3'd2,
		ST_NOTFOUND  = 3'd3,
		ST_DELETED   = 3'd4,
		ST_EMPTY     = 3'd5,
		ST_FULL      = 3'd6,
		ST_LISTED    = 3'd7
	} status_t;

	// what every cell does in a cycle
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_DELETE,
		CELL_ROTATE
	} cell_op_t;

	// broadcast control for the cell row
	typedef struct packed {
		cell_op_t                op;
		logic signed [VAL_W-1:0] key;
	} chain_ctrl_t;

	// one-hot vector to index
	function automatic logic [IDX_W-1:0] onehot_index(input logic [CAPACITY-1:0] vec);
		logic [IDX_W-1:0] idx;
		idx = '0;
		for (int j = 0; j < CAPACITY; j++) begin
			if (vec[j]) begin
				idx = idx | IDX_W'(j);
			end
		end
		return idx;
	endfunction

endpackage

// ===== hdl/ssisd_cell.sv =====
// ----------------------------------------------------------------------------
// ssisd_cell: one slot of the sorted row
// Holds one value, compares it with the broadcast key and takes a neighbor's
// value when the row opens a gap, closes a gap or rotates.
// ----------------------------------------------------------------------------
module ssisd_cell (
	input  logic                                 clk,
	input  ssisd_pkg::chain_ctrl_t               ctrl,
	input  logic                                 occ,
	input  logic                                 next_occ,
	input  logic                                 left_lt,
	input  logic signed [ssisd_pkg::VAL_W-1:0]   left_val,
	input  logic signed [ssisd_pkg::VAL_W-1:0]   right_val,
	input  logic signed [ssisd_pkg::VAL_W-1:0]   head_val,
	output logic signed [ssisd_pkg::VAL_W-1:0]   value,
	output logic                                 lt,
	output logic                                 eq
);

	logic signed [ssisd_pkg::VAL_W-1:0] entry_q;

	// compare against the key, only occupied slots count
	assign lt    = occ && (entry_q < ctrl.key);
	assign eq    = occ && (entry_q == ctrl.key);
	assign value = entry_q;

	// shift, insert or rotate
	always_ff @(posedge clk) begin
		case (ctrl.op)
			ssisd_pkg::CELL_INSERT: begin
				if (!lt) begin
					entry_q <= left_lt ? ctrl.key : left_val;
				end
			end
			ssisd_pkg::CELL_DELETE: begin
				if (!lt) begin
					entry_q <= right_val;
				end
			end
			ssisd_pkg::CELL_ROTATE: begin
				entry_q <= (occ && !next_occ) ? head_val : right_val;
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

endmodule

// ===== hdl/ssisd_chain.sv =====
// ----------------------------------------------------------------------------
// ssisd_chain: row of sorted cells
// Wires the cells to their neighbors and gathers the compare flags.
// ----------------------------------------------------------------------------
module ssisd_chain (
	input  logic                                 clk,
	input  ssisd_pkg::chain_ctrl_t               ctrl,
	input  logic [ssisd_pkg::CAPACITY-1:0]       occ,
	output logic [ssisd_pkg::CAPACITY-1:0]       lt_vec,
	output logic [ssisd_pkg::CAPACITY-1:0]       eq_vec,
	output logic signed [ssisd_pkg::VAL_W-1:0]   head_val
);

	logic signed [ssisd_pkg::VAL_W-1:0] vals [ssisd_pkg::CAPACITY];

	assign head_val = vals[0];

	// one cell per slot, neighbors on both sides
	for (genvar j = 0; j < ssisd_pkg::CAPACITY; j++) begin : g_cell
		logic                               left_lt;
		logic                               next_occ;
		logic signed [ssisd_pkg::VAL_W-1:0] left_val;
		logic signed [ssisd_pkg::VAL_W-1:0] right_val;

		if (j == 0) begin : g_first
			assign left_lt  = 1'b1;
			assign left_val = ctrl.key;
		end else begin : g_inner
			assign left_lt  = lt_vec[j-1];
			assign left_val = vals[j-1];
		end

		if (j == ssisd_pkg::CAPACITY - 1) begin : g_last
			assign next_occ  = 1'b0;
			assign right_val = vals[j];
		end else begin : g_body
			assign next_occ  = occ[j+1];
			assign right_val = vals[j+1];
		end

		ssisd_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.occ       (occ[j]),
			.next_occ  (next_occ),
			.left_lt   (left_lt),
			.left_val  (left_val),
			.right_val (right_val),
			.head_val  (head_val),
			.value     (vals[j]),
			.lt        (lt_vec[j]),
			.eq        (eq_vec[j])
		);
	end

endmodule

// ===== hdl/sorted_set_insert_search_delete_unit.sv =====
// A request is registered on acceptance and its result in the exec state once
// the result slot is free; req_stall holds off new requests until then. A dump
// of n > 0 entries rotates the row once round after a setup step, giving n
// results, one per cycle; stalls on the result side hold the row.
// Reset clears the entry count and all control state; stored values are not
// reset and are never read before they are written.
// ----------------------------------------------------------------------------
// sorted_set_insert_search_delete_unit: sorted set of signed values
// Keeps distinct values in ascending order in a row of compare-and-shift
// cells and answers insert, search, delete, dump and clear requests.
// ----------------------------------------------------------------------------
module sorted_set_insert_search_delete_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  logic [ssisd_pkg::KIND_W-1:0]         kind,
	input  logic signed [ssisd_pkg::VAL_W-1:0]   value,
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output logic [ssisd_pkg::STAT_W-1:0]         status,
	output logic [ssisd_pkg::POS_W-1:0]          position,
	output logic signed [ssisd_pkg::VAL_W-1:0]   entry_value,
	output logic [ssisd_pkg::POS_W-1:0]          entry_count,
	output logic                                 last
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DUMP
	} state_t;

	state_t                                state_q;
	ssisd_pkg::kind_t                      kind_q;
	logic signed [ssisd_pkg::VAL_W-1:0]    key_q;
	logic [ssisd_pkg::CNT_W-1:0]           count_q;
	logic [ssisd_pkg::IDX_W-1:0]           dump_q;
	logic                                  res_valid_q;
	ssisd_pkg::status_t                    status_q;
	logic [ssisd_pkg::POS_W-1:0]           position_q;
	logic signed [ssisd_pkg::VAL_W-1:0]    entry_value_q;
	logic [ssisd_pkg::POS_W-1:0]           entry_count_q;
	logic                                  last_q;

	ssisd_pkg::chain_ctrl_t                ctrl;
	logic [ssisd_pkg::CAPACITY-1:0]        occ;
	logic [ssisd_pkg::CAPACITY-1:0]        lt_vec;
	logic [ssisd_pkg::CAPACITY-1:0]        eq_vec;
	logic [ssisd_pkg::CAPACITY-1:0]        bnd;
	logic signed [ssisd_pkg::VAL_W-1:0]    head_val;
	logic [ssisd_pkg::CNT_W-1:0]           pos_full;
	logic [ssisd_pkg::CNT_W-1:0]           dump_pos;
	logic                                  out_free;
	logic                                  found;
	logic                                  full;
	logic                                  empty;
	logic                                  dump_last;

	// handshake outputs
	assign req_stall   = (state_q != S_IDLE);
	assign res_valid   = res_valid_q;
	assign status      = status_q;
	assign position    = position_q;
	assign entry_value = entry_value_q;
	assign entry_count = entry_count_q;
	assign last        = last_q;

	// result slot is free when empty or being taken
	assign out_free = !res_valid_q || !res_stall;

	// occupied slots as a thermometer
	always_comb begin
		for (int j = 0; j < ssisd_pkg::CAPACITY; j++) begin
			occ[j] = (ssisd_pkg::CNT_W'(j) < count_q);
		end
	end

	// lower bound: first slot not below the key
	always_comb begin
		for (int j = 0; j < ssisd_pkg::CAPACITY; j++) begin
			if (j == 0) begin
				bnd[j] = !lt_vec[j];
			end else begin
				bnd[j] = !lt_vec[j] && lt_vec[j-1];
			end
		end
	end

	assign pos_full  = ssisd_pkg::CNT_W'(ssisd_pkg::onehot_index(bnd)) + ssisd_pkg::CNT_W'(1);
	assign found     = |eq_vec;
	assign full      = (count_q == ssisd_pkg::CNT_W'(ssisd_pkg::CAPACITY));
	assign empty     = (count_q == '0);
	assign dump_pos  = ssisd_pkg::CNT_W'(dump_q) + ssisd_pkg::CNT_W'(1);
	assign dump_last = (dump_pos == count_q);

	// row control for this cycle
	always_comb begin
		ctrl.key = key_q;
		ctrl.op  = ssisd_pkg::CELL_HOLD;
		if (state_q == S_EXEC && out_free) begin
			if (kind_q == ssisd_pkg::KIND_INSERT && !found && !full) begin
				ctrl.op = ssisd_pkg::CELL_INSERT;
			end else if (kind_q == ssisd_pkg::KIND_DELETE && found) begin
				ctrl.op = ssisd_pkg::CELL_DELETE;
			end
		end else if (state_q == S_DUMP && out_free) begin
			ctrl.op = ssisd_pkg::CELL_ROTATE;
		end
	end

	ssisd_chain u_chain (
		.clk      (clk),
		.ctrl     (ctrl),
		.occ      (occ),
		.lt_vec   (lt_vec),
		.eq_vec   (eq_vec),
		.head_val (head_val)
	);

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			kind_q        <= ssisd_pkg::KIND_INSERT;
			key_q         <= '0;
			count_q       <= '0;
			dump_q        <= '0;
			res_valid_q   <= 1'b0;
			status_q      <= ssisd_pkg::ST_INSERTED;
			position_q    <= '0;
			entry_value_q <= '0;
			entry_count_q <= '0;
			last_q        <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid && kind <= ssisd_pkg::KIND_CLEAR) begin
						kind_q  <= ssisd_pkg::kind_t'(kind);
						key_q   <= value;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (out_free) begin
						res_valid_q   <= 1'b1;
						last_q        <= 1'b1;
						position_q    <= '0;
						entry_value_q <= key_q;
						entry_count_q <= ssisd_pkg::POS_W'(count_q);
						state_q       <= S_IDLE;
						if (kind_q == ssisd_pkg::KIND_INSERT) begin
							if (found) begin
								status_q   <= ssisd_pkg::ST_DUPLICATE;
								position_q <= ssisd_pkg::POS_W'(pos_full);
							end else if (full) begin
								status_q <= ssisd_pkg::ST_FULL;
							end else begin
								status_q      <= ssisd_pkg::ST_INSERTED;
								position_q    <= ssisd_pkg::POS_W'(pos_full);
								count_q       <= count_q + ssisd_pkg::CNT_W'(1);
								entry_count_q <= ssisd_pkg::POS_W'(count_q + ssisd_pkg::CNT_W'(1));
							end
						end else if (empty) begin
							status_q <= ssisd_pkg::ST_EMPTY;
							if (kind_q == ssisd_pkg::KIND_DUMP || kind_q == ssisd_pkg::KIND_CLEAR) begin
								entry_value_q <= '0;
							end
						end else if (kind_q == ssisd_pkg::KIND_SEARCH) begin
							if (found) begin
								status_q   <= ssisd_pkg::ST_FOUND;
								position_q <= ssisd_pkg::POS_W'(pos_full);
							end else begin
								status_q <= ssisd_pkg::ST_NOTFOUND;
							end
						end else if (kind_q == ssisd_pkg::KIND_DELETE) begin
							if (found) begin
								status_q      <= ssisd_pkg::ST_DELETED;
								position_q    <= ssisd_pkg::POS_W'(pos_full);
								count_q       <= count_q - ssisd_pkg::CNT_W'(1);
								entry_count_q <= ssisd_pkg::POS_W'(count_q - ssisd_pkg::CNT_W'(1));
							end else begin
								status_q <= ssisd_pkg::ST_NOTFOUND;
							end
						end else if (kind_q == ssisd_pkg::KIND_DUMP) begin
							// no result yet, the walk starts next cycle
							res_valid_q <= 1'b0;
							dump_q      <= '0;
							state_q     <= S_DUMP;
						end else begin
							status_q      <= ssisd_pkg::ST_LISTED;
							entry_value_q <= '0;
							entry_count_q <= '0;
							count_q       <= '0;
						end
					end
				end
				S_DUMP: begin
					if (out_free) begin
						res_valid_q   <= 1'b1;
						status_q      <= ssisd_pkg::ST_LISTED;
						position_q    <= ssisd_pkg::POS_W'(dump_pos);
						entry_value_q <= head_val;
						entry_count_q <= ssisd_pkg::POS_W'(count_q);
						last_q        <= dump_last;
						dump_q        <= dump_q + ssisd_pkg::IDX_W'(1);
						if (dump_last) begin
							dump_q  <= '0;
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// entry count stays within capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ssisd_pkg::CNT_W'(ssisd_pkg::CAPACITY))
		else $error("entry count above capacity");

	// stored values are distinct, so at most one slot matches
	assert property (@(posedge clk) disable iff (!arst_n) $onehot0(eq_vec))
		else $error("more than one slot matches the key");

	// an insert always finds exactly one gap position
	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.op == ssisd_pkg::CELL_INSERT |-> $onehot(bnd))
		else $error("insert without a single gap position");

	// the entry count does not move during a dump walk
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DUMP |=> $stable(count_q))
		else $error("entry count changed during dump");

	// a dump walk never runs past the stored entries
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DUMP |-> dump_pos <= count_q)
		else $error("dump index beyond entry count");

endmodule
